// ----- rtl/core/mcat_pkg.sv -----
// Shared types and constants for the mesh core assignment table.
package mcat_pkg;

    // Field widths of the command and result transactions
    localparam int CMD_W    = 3;
    localparam int ROUTER_W = 6;
    localparam int CORE_W   = 6;
    localparam int LINE_W   = 3;
    localparam int CFG_W    = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ASSIGN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWAP_ROWS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SWAP_COLS = 3'd5;

    // Configuration register indexes and reset value
    localparam logic CFG_MESH_ROWS = 1'b0;
    localparam logic CFG_MESH_COLS = 1'b1;
    localparam logic [CFG_W-1:0] CFG_LINES_RESET = 4'd8;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ROUTER_W-1:0] router_index;
        logic [CORE_W-1:0]   core_id;
        logic [LINE_W-1:0]   first_line;
        logic [LINE_W-1:0]   second_line;
    } t_cmd_in;

    typedef struct packed {
        logic                ok;
        logic                assigned;
        logic [CORE_W-1:0]   core_out;
        logic [ROUTER_W-1:0] found_router;
    } t_result;

endpackage

// ----- rtl/core/mcat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mcat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mesh_core_assignment_table_core.sv -----
// Mesh core assignment table: router-to-core table with command sequencer.
//
// One command is taken when start is high and busy is low; exactly one result
// follows, shown on o_result for a single cycle while o_valid is high, and the
// receiver must take it then. All table accesses go through one RAM with one
// write and one registered read port: assign and read fetch the entry from idle
// and act on it in an evaluate state, find checks one entry per cycle up to
// rows*cols entries and stops at the first hit, clear writes one entry per
// cycle across all MAX_ROWS*MAX_COLS entries, and a row or column swap reads
// both entries and writes both back for each exchanged pair. Rejected swaps,
// out-of-range reads or assigns and unused codes answer from idle. After reset
// the block clears all MAX_ROWS*MAX_COLS entries with busy high; configuration
// writes are taken at any time but should only be issued while busy is low.
module mesh_core_assignment_table_core #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 8,
    parameter int CORE_BITS = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  mcat_pkg::t_cmd_in         i_cmd,
    output logic                      o_valid,
    output mcat_pkg::t_result         o_result,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [mcat_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int LIN_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int LCMP_W = (LIN_W > mcat_pkg::LINE_W) ? LIN_W : mcat_pkg::LINE_W;
    localparam int RCMP_W = (CNT_W > mcat_pkg::ROUTER_W) ? CNT_W : mcat_pkg::ROUTER_W;
    localparam int KCMP_W = (CORE_BITS > mcat_pkg::CORE_W) ? CORE_BITS : mcat_pkg::CORE_W;
    localparam int ENT_W  = CORE_BITS + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_FIND = 8'b0000_0100,
        S_CLR  = 8'b0000_1000,
        S_SWRA = 8'b0001_0000,
        S_SWRB = 8'b0010_0000,
        S_SWWA = 8'b0100_0000,
        S_SWWB = 8'b1000_0000
    } t_state;

    t_state                    r_state, n_state;
    mcat_pkg::t_cmd_in         r_in, n_in;
    mcat_pkg::t_result         r_res, n_res;
    logic                      r_valid, n_valid;
    logic                      r_init, n_init;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic                      r_chk, n_chk;
    logic [CNT_W-1:0]          r_chk_idx, n_chk_idx;
    logic [CNT_W-1:0]          r_addr_a, n_addr_a;
    logic [CNT_W-1:0]          r_addr_b, n_addr_b;
    logic [CNT_W-1:0]          r_step, n_step;
    logic [LIN_W-1:0]          r_left, n_left;
    logic [ENT_W-1:0]          r_hold, n_hold;
    logic [mcat_pkg::CFG_W-1:0] r_mesh_rows, n_mesh_rows;
    logic [mcat_pkg::CFG_W-1:0] r_mesh_cols, n_mesh_cols;

    logic [ROW_W-1:0] w_rows;
    logic [COL_W-1:0] w_cols;
    logic [CNT_W-1:0] w_count;
    logic             w_rows_ok;
    logic             w_cols_ok;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_raddr;
    logic [ENT_W-1:0] w_rdata;

    // Clamp the configured mesh size into 1..MAX
    always_comb begin
        if (r_mesh_rows == '0) begin
            w_rows = ROW_W'(1);
        end else if (8'(r_mesh_rows) > 8'(MAX_ROWS)) begin
            w_rows = ROW_W'(MAX_ROWS);
        end else begin
            w_rows = ROW_W'(r_mesh_rows);
        end
        if (r_mesh_cols == '0) begin
            w_cols = COL_W'(1);
        end else if (8'(r_mesh_cols) > 8'(MAX_COLS)) begin
            w_cols = COL_W'(MAX_COLS);
        end else begin
            w_cols = COL_W'(r_mesh_cols);
        end
        w_count = CNT_W'(CNT_W'(w_rows) * CNT_W'(w_cols));
    end

    // Check swap line numbers against the line counts
    assign w_rows_ok = (LCMP_W'(i_cmd.first_line) < LCMP_W'(w_rows))
                    && (LCMP_W'(i_cmd.second_line) < LCMP_W'(w_rows))
                    && (i_cmd.first_line != i_cmd.second_line);
    assign w_cols_ok = (LCMP_W'(i_cmd.first_line) < LCMP_W'(w_cols))
                    && (LCMP_W'(i_cmd.second_line) < LCMP_W'(w_cols))
                    && (i_cmd.first_line != i_cmd.second_line);

    // Sequence table accesses for each command
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_res       = r_res;
        n_valid     = 1'b0;
        n_init      = r_init;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_addr_a    = r_addr_a;
        n_addr_b    = r_addr_b;
        n_step      = r_step;
        n_left      = r_left;
        n_hold      = r_hold;
        n_mesh_rows = r_mesh_rows;
        n_mesh_cols = r_mesh_cols;
        w_we        = 1'b0;
        w_waddr     = IDX_W'(r_idx);
        w_wdata     = '0;
        w_raddr     = IDX_W'(r_idx);

        unique case (r_state)
            S_IDLE: begin
                w_raddr = IDX_W'(i_cmd.router_index);
                if (start) begin
                    n_in  = i_cmd;
                    n_res = '0;
                    unique case (i_cmd.command) inside
                        mcat_pkg::CMD_ASSIGN, mcat_pkg::CMD_READ: begin
                            if (RCMP_W'(i_cmd.router_index) < RCMP_W'(w_count)) begin
                                n_state = S_EVAL;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        mcat_pkg::CMD_FIND: begin
                            n_idx   = '0;
                            n_chk   = 1'b0;
                            n_state = S_FIND;
                        end
                        mcat_pkg::CMD_CLEAR: begin
                            n_idx   = '0;
                            n_init  = 1'b0;
                            n_state = S_CLR;
                        end
                        mcat_pkg::CMD_SWAP_ROWS: begin
                            if (w_rows_ok) begin
                                n_addr_a = CNT_W'(CNT_W'(i_cmd.first_line) * CNT_W'(w_cols));
                                n_addr_b = CNT_W'(CNT_W'(i_cmd.second_line) * CNT_W'(w_cols));
                                n_step   = CNT_W'(1);
                                n_left   = LIN_W'(w_cols);
                                n_state  = S_SWRA;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        mcat_pkg::CMD_SWAP_COLS: begin
                            if (w_cols_ok) begin
                                n_addr_a = CNT_W'(i_cmd.first_line);
                                n_addr_b = CNT_W'(i_cmd.second_line);
                                n_step   = CNT_W'(w_cols);
                                n_left   = LIN_W'(w_rows);
                                n_state  = S_SWRA;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                // Entry at router_index is on the read port now
                if (r_in.command == mcat_pkg::CMD_ASSIGN) begin
                    if (!w_rdata[CORE_BITS]) begin
                        w_we     = 1'b1;
                        w_waddr  = IDX_W'(r_in.router_index);
                        w_wdata  = {1'b1, CORE_BITS'(r_in.core_id)};
                        n_res.ok = 1'b1;
                    end
                end else begin
                    n_res.ok       = 1'b1;
                    n_res.assigned = w_rdata[CORE_BITS];
                    if (w_rdata[CORE_BITS]) begin
                        n_res.core_out = mcat_pkg::CORE_W'(w_rdata[CORE_BITS-1:0]);
                    end
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_FIND: begin
                // Issue one read per cycle, check the one issued last cycle
                w_raddr = IDX_W'(r_idx);
                if (r_chk && w_rdata[CORE_BITS]
                        && (KCMP_W'(w_rdata[CORE_BITS-1:0]) == KCMP_W'(r_in.core_id))) begin
                    n_res.ok           = 1'b1;
                    n_res.found_router = mcat_pkg::ROUTER_W'(r_chk_idx);
                    n_valid            = 1'b1;
                    n_state            = S_IDLE;
                end else if (r_idx < w_count) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx;
                    n_idx     = r_idx + CNT_W'(1);
                end else if (!r_chk) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_chk = 1'b0;
                end
            end
            S_CLR: begin
                // Sweep the whole table to unassigned
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_idx);
                w_wdata = '0;
                if (r_idx == CNT_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                    if (!r_init) begin
                        n_res.ok = 1'b1;
                        n_valid  = 1'b1;
                    end
                    n_init = 1'b0;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_SWRA: begin
                w_raddr = IDX_W'(r_addr_a);
                n_state = S_SWRB;
            end
            S_SWRB: begin
                w_raddr = IDX_W'(r_addr_b);
                n_hold  = w_rdata;
                n_state = S_SWWA;
            end
            S_SWWA: begin
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_addr_a);
                w_wdata = w_rdata;
                n_state = S_SWWB;
            end
            S_SWWB: begin
                w_we    = 1'b1;
                w_waddr = IDX_W'(r_addr_b);
                w_wdata = r_hold;
                if (r_left == LIN_W'(1)) begin
                    n_res.ok = 1'b1;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_left   = r_left - LIN_W'(1);
                    n_addr_a = r_addr_a + r_step;
                    n_addr_b = r_addr_b + r_step;
                    n_state  = S_SWRA;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Take configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mcat_pkg::CFG_MESH_ROWS: n_mesh_rows = i_cfg_wdata;
                mcat_pkg::CFG_MESH_COLS: n_mesh_cols = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance control and hold payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init      <= 1'b1;
            r_idx       <= '0;
            r_chk       <= 1'b0;
            r_valid     <= 1'b0;
            r_mesh_rows <= mcat_pkg::CFG_LINES_RESET;
            r_mesh_cols <= mcat_pkg::CFG_LINES_RESET;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_idx       <= n_idx;
            r_chk       <= n_chk;
            r_valid     <= n_valid;
            r_mesh_rows <= n_mesh_rows;
            r_mesh_cols <= n_mesh_cols;
        end
        r_in      <= n_in;
        r_res     <= n_res;
        r_chk_idx <= n_chk_idx;
        r_addr_a  <= n_addr_a;
        r_addr_b  <= n_addr_b;
        r_step    <= n_step;
        r_left    <= n_left;
        r_hold    <= n_hold;
    end

    mcat_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the mesh core assignment table.
`timescale 1ns / 100ps

module tb;

    localparam int MESH_MAX_ROWS  = 8;
    localparam int MESH_MAX_COLS  = 8;
    localparam int MAP_DEPTH      = MESH_MAX_ROWS * MESH_MAX_COLS;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 70;
    localparam int ITEMS_PER_STEP = 45;
    localparam int PLAN_STEPS     = 9;

    // Codes the block leaves unused
    localparam logic [mcat_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [mcat_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Mirror of the router-to-core map; queues the reply each command should give
    class core_map_tracker;
        logic [mcat_pkg::CORE_W:0]   entries [MAP_DEPTH];
        logic [mcat_pkg::CFG_W-1:0]  rows_reg;
        logic [mcat_pkg::CFG_W-1:0]  cols_reg;
        mcat_pkg::t_result           pending_replies [$];
        int unsigned                 mismatches;

        function new();
            foreach (entries[i]) entries[i] = '0;
            rows_reg   = mcat_pkg::CFG_LINES_RESET;
            cols_reg   = mcat_pkg::CFG_LINES_RESET;
            mismatches = 0;
        endfunction

        // Clamp a raw line count to 1..limit
        function int unsigned lines_in_use(logic [mcat_pkg::CFG_W-1:0] raw,
                                           int unsigned limit);
            if (raw == 0) return 1;
            if (raw > limit) return limit;
            return 32'(raw);
        endfunction

        function int unsigned rows_in_use();
            return lines_in_use(rows_reg, MESH_MAX_ROWS);
        endfunction

        function int unsigned cols_in_use();
            return lines_in_use(cols_reg, MESH_MAX_COLS);
        endfunction

        function void write_register(logic idx, logic [mcat_pkg::CFG_W-1:0] value);
            if (idx == mcat_pkg::CFG_MESH_ROWS) begin
                rows_reg = value;
            end else begin
                cols_reg = value;
            end
        endfunction

        // Update the map for an accepted command and queue its reply
        function void apply_command(mcat_pkg::t_cmd_in c);
            mcat_pkg::t_result         r;
            int unsigned               rows;
            int unsigned               cols;
            int unsigned               count;
            int unsigned               a;
            int unsigned               b;
            logic [mcat_pkg::CORE_W:0] held;
            rows  = rows_in_use();
            cols  = cols_in_use();
            count = rows * cols;
            r     = '0;
            case (c.command)
                mcat_pkg::CMD_ASSIGN: begin
                    if (c.router_index < count
                            && !entries[c.router_index][mcat_pkg::CORE_W]) begin
                        entries[c.router_index] = {1'b1, c.core_id};
                        r.ok = 1'b1;
                    end
                end
                mcat_pkg::CMD_READ: begin
                    if (c.router_index < count) begin
                        r.ok = 1'b1;
                        if (entries[c.router_index][mcat_pkg::CORE_W]) begin
                            r.assigned = 1'b1;
                            r.core_out = entries[c.router_index][mcat_pkg::CORE_W-1:0];
                        end
                    end
                end
                mcat_pkg::CMD_FIND: begin
                    for (int i = 0; i < count; i++) begin
                        if (entries[i][mcat_pkg::CORE_W]
                                && entries[i][mcat_pkg::CORE_W-1:0] == c.core_id) begin
                            r.ok           = 1'b1;
                            r.found_router = mcat_pkg::ROUTER_W'(i);
                            break;
                        end
                    end
                end
                mcat_pkg::CMD_CLEAR: begin
                    foreach (entries[i]) entries[i] = '0;
                    r.ok = 1'b1;
                end
                mcat_pkg::CMD_SWAP_ROWS: begin
                    if (c.first_line < rows && c.second_line < rows &&
                        c.first_line != c.second_line) begin
                        for (int i = 0; i < cols; i++) begin
                            a = c.first_line * cols + i;
                            b = c.second_line * cols + i;
                            held       = entries[a];
                            entries[a] = entries[b];
                            entries[b] = held;
                        end
                        r.ok = 1'b1;
                    end
                end
                mcat_pkg::CMD_SWAP_COLS: begin
                    if (c.first_line < cols && c.second_line < cols &&
                        c.first_line != c.second_line) begin
                        for (int i = 0; i < rows; i++) begin
                            a = i * cols + c.first_line;
                            b = i * cols + c.second_line;
                            held       = entries[a];
                            entries[a] = entries[b];
                            entries[b] = held;
                        end
                        r.ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare a reply field by field with the oldest queued one
        task compare_result(mcat_pkg::t_result got);
            mcat_pkg::t_result want;
            if (pending_replies.size() == 0) begin
                report("reply with no command outstanding");
            end else begin
                want = pending_replies.pop_front();
                if (got.ok !== want.ok)
                    report($sformatf("ok %b, want %b", got.ok, want.ok));
                if (got.assigned !== want.assigned)
                    report($sformatf("assigned %b, want %b", got.assigned, want.assigned));
                if (got.core_out !== want.core_out)
                    report($sformatf("core_out %0d, want %0d", got.core_out, want.core_out));
                if (got.found_router !== want.found_router)
                    report($sformatf("found_router %0d, want %0d",
                                     got.found_router, want.found_router));
            end
        endtask
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    mcat_pkg::t_cmd_in             i_cmd       = '0;
    logic                          o_valid;
    mcat_pkg::t_result             o_result;
    logic                          i_cfg_we    = 1'b0;
    logic                          i_cfg_idx   = mcat_pkg::CFG_MESH_ROWS;
    logic [mcat_pkg::CFG_W-1:0]    i_cfg_wdata = '0;

    core_map_tracker tracker = new();
    bit              allow_idle = 1'b1;
    int unsigned     idle_cycles = 0;
    int unsigned     plan_rows [PLAN_STEPS] = '{3, 0, 15, 1, 8, 9, 2, 0, 0};
    int unsigned     plan_cols [PLAN_STEPS] = '{5, 15, 0, 1, 8, 2, 9, 0, 0};

    mesh_core_assignment_table_core #(
        .MAX_ROWS  (MESH_MAX_ROWS),
        .MAX_COLS  (MESH_MAX_COLS),
        .CORE_BITS (mcat_pkg::CORE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Observe every transaction, check replies, and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                tracker.compare_result(o_result);
            if (start && !busy)
                tracker.apply_command(i_cmd);
            if (i_cfg_we)
                tracker.write_register(i_cfg_idx, i_cfg_wdata);
        end
        if ((start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic mcat_pkg::t_cmd_in command_item(logic [mcat_pkg::CMD_W-1:0] op,
                                                       int unsigned rix,
                                                       int unsigned core,
                                                       int unsigned first,
                                                       int unsigned second);
        mcat_pkg::t_cmd_in c;
        c.command      = op;
        c.router_index = mcat_pkg::ROUTER_W'(rix);
        c.core_id      = mcat_pkg::CORE_W'(core);
        c.first_line   = mcat_pkg::LINE_W'(first);
        c.second_line  = mcat_pkg::LINE_W'(second);
        return c;
    endfunction

    // Present one command after an optional random gap; hold until taken
    task automatic send_command(mcat_pkg::t_cmd_in c);
        while (allow_idle && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and wait for every queued reply to come back
    task automatic drain_replies();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_replies.size() != 0);
    endtask

    // Write both mesh dimensions back to back while the block is idle
    task automatic set_mesh_size(int unsigned rows, int unsigned cols);
        while (busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= mcat_pkg::CFG_MESH_ROWS;
        i_cfg_wdata <= mcat_pkg::CFG_W'(rows);
        @(posedge i_clk);
        i_cfg_idx   <= mcat_pkg::CFG_MESH_COLS;
        i_cfg_wdata <= mcat_pkg::CFG_W'(cols);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly in-bounds commands over a small core pool, some wild ones mixed in
    task automatic send_random_commands(int unsigned n);
        int unsigned                 pick;
        int unsigned                 rows;
        int unsigned                 cols;
        int unsigned                 lim;
        int unsigned                 rix;
        int unsigned                 core;
        logic [mcat_pkg::CMD_W-1:0]  op;
        for (int k = 0; k < n; k++) begin
            rows = tracker.rows_in_use();
            cols = tracker.cols_in_use();
            pick = $urandom_range(0, 99);
            if (pick < 30)      op = mcat_pkg::CMD_ASSIGN;
            else if (pick < 50) op = mcat_pkg::CMD_READ;
            else if (pick < 70) op = mcat_pkg::CMD_FIND;
            else if (pick < 82) op = mcat_pkg::CMD_SWAP_ROWS;
            else if (pick < 94) op = mcat_pkg::CMD_SWAP_COLS;
            else if (pick < 96) op = mcat_pkg::CMD_CLEAR;
            else                op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            lim  = (op == mcat_pkg::CMD_SWAP_COLS) ? cols : rows;
            rix  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, rows * cols - 1)
                                              : $urandom_range(0, 63);
            core = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63);
            send_command(command_item(op, rix, core,
                ($urandom_range(0, 3) < 3) ? $urandom_range(0, lim - 1) : $urandom_range(0, 7),
                ($urandom_range(0, 3) < 3) ? $urandom_range(0, lim - 1) : $urandom_range(0, 7)));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full 8x8 mesh straight out of reset
        send_command(command_item(mcat_pkg::CMD_READ, 0, 0, 0, 0));
        send_command(command_item(mcat_pkg::CMD_ASSIGN, 0, 0, 0, 0));
        send_command(command_item(mcat_pkg::CMD_ASSIGN, 63, 63, 7, 7));
        send_command(command_item(mcat_pkg::CMD_ASSIGN, 0, 42, 0, 0));     // router taken
        send_command(command_item(mcat_pkg::CMD_READ, 0, 0, 0, 0));
        send_command(command_item(mcat_pkg::CMD_READ, 63, 0, 0, 0));
        send_command(command_item(mcat_pkg::CMD_ASSIGN, 9, 63, 0, 0));     // same core twice
        send_command(command_item(mcat_pkg::CMD_FIND, 0, 63, 0, 0));       // lowest index wins
        send_command(command_item(mcat_pkg::CMD_FIND, 0, 0, 0, 0));
        send_command(command_item(mcat_pkg::CMD_FIND, 0, 21, 0, 0));       // no match
        send_command(command_item(mcat_pkg::CMD_SWAP_ROWS, 0, 0, 0, 7));
        send_command(command_item(mcat_pkg::CMD_SWAP_ROWS, 0, 0, 3, 3));   // equal lines
        send_command(command_item(mcat_pkg::CMD_SWAP_COLS, 0, 0, 7, 0));
        send_command(command_item(mcat_pkg::CMD_SWAP_COLS, 0, 0, 2, 2));
        send_command(command_item(mcat_pkg::CMD_READ, 63, 0, 0, 0));
        send_command(command_item(mcat_pkg::CMD_FIND, 0, 63, 0, 0));
        send_command(command_item(CMD_SPARE_LO, 63, 63, 7, 7));
        send_command(command_item(CMD_SPARE_HI, 63, 63, 7, 7));
        send_command(command_item(mcat_pkg::CMD_CLEAR, 0, 0, 0, 0));
        send_command(command_item(mcat_pkg::CMD_READ, 63, 0, 0, 0));
        send_random_commands(ITEMS_PER_STEP);

        plan_rows[7] = $urandom_range(1, 8);
        plan_cols[7] = $urandom_range(1, 8);
        plan_rows[8] = $urandom_range(0, 15);
        plan_cols[8] = $urandom_range(0, 15);
        for (int p = 0; p < PLAN_STEPS; p++) begin
            drain_replies();
            set_mesh_size(plan_rows[p], plan_cols[p]);
            if (p == 0) begin
                // 3x5 mesh: line index equal to the line count, index past the end
                send_command(command_item(mcat_pkg::CMD_SWAP_ROWS, 0, 0, 2, 3));
                send_command(command_item(mcat_pkg::CMD_SWAP_COLS, 0, 0, 5, 4));
                send_command(command_item(mcat_pkg::CMD_READ, 15, 0, 0, 0));
                send_command(command_item(mcat_pkg::CMD_ASSIGN, 15, 1, 0, 0));
            end
            // Run the full 8x8 step back to back with no gaps
            allow_idle = (p != 4);
            send_random_commands(ITEMS_PER_STEP);
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
